// ===== src/segment_intersection_core_assert.svh =====
// assertion macros for the segment intersection core
`ifndef SEGMENT_INTERSECTION_CORE_ASSERT_SVH
`define SEGMENT_INTERSECTION_CORE_ASSERT_SVH

`ifndef SYNTH
// checked while out of reset
`define SEGI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked on every edge, reset included
`define SEGI_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SEGI_ASSERT(lbl, prop, msg)
`define SEGI_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== src/segi_pkg.sv =====
`default_nettype none
package segi_pkg;

	// field and datapath widths
	localparam int COORD_W = 16;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int NUM_W   = CROSS_W + DIFF_W;
	localparam int QUO_W   = DIFF_W;
	localparam int THR_W   = 32;

	// status codes
	localparam logic [1:0] ST_HIT      = 2'd0;
	localparam logic [1:0] ST_PARALLEL = 2'd1;
	localparam logic [1:0] ST_T_OUT    = 2'd2;
	localparam logic [1:0] ST_U_OUT    = 2'd3;

	// data that rides alongside the division
	typedef struct packed {
		logic [1:0]                 status;
		logic signed [COORD_W-1:0] ax;
		logic signed [COORD_W-1:0] ay;
	} side_t;

endpackage
`default_nettype wire

// ===== src/segi_div.sv =====
`default_nettype none
module segi_div (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                en,
	input  wire logic                                in_vld,
	input  wire logic signed [segi_pkg::NUM_W-1:0]   num_x,
	input  wire logic signed [segi_pkg::NUM_W-1:0]   num_y,
	input  wire logic signed [segi_pkg::CROSS_W-1:0] den,
	input  wire segi_pkg::side_t                     side_in,
	output logic                                     res_vld,
	output logic signed [segi_pkg::DIFF_W:0]         quo_x,
	output logic signed [segi_pkg::DIFF_W:0]         quo_y,
	output segi_pkg::side_t                          side_res
);

	localparam int QW = segi_pkg::QUO_W;
	localparam int RW = segi_pkg::CROSS_W;
	localparam int NW = segi_pkg::NUM_W;

	logic [RW-1:0]   rem_x [0:QW];
	logic [RW-1:0]   rem_y [0:QW];
	logic [QW-1:0]   lo_x  [0:QW];
	logic [QW-1:0]   lo_y  [0:QW];
	logic [RW-1:0]   dv    [0:QW];
	logic            neg_x [0:QW];
	logic            neg_y [0:QW];
	logic            vld   [0:QW];
	segi_pkg::side_t sd    [0:QW];

	logic [NW-1:0] mag_x, mag_y;
	logic [RW:0]   den_e, mag_d;

	// magnitudes and quotient signs
	always_comb begin
		mag_x = num_x[NW-1] ? NW'(-num_x) : NW'(num_x);
		mag_y = num_y[NW-1] ? NW'(-num_y) : NW'(num_y);
		den_e = {den[RW-1], den};
		mag_d = den[RW-1] ? (RW+1)'(-den_e) : den_e;
	end

	// entry register: dividend split so the first remainder is below the divisor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld[0] <= 1'b0;
		end else if (en) begin
			vld[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_x[0] <= mag_x[NW-1:QW];
			rem_y[0] <= mag_y[NW-1:QW];
			lo_x[0]  <= mag_x[QW-1:0];
			lo_y[0]  <= mag_y[QW-1:0];
			dv[0]    <= mag_d[RW-1:0];
			neg_x[0] <= num_x[NW-1] ^ den[RW-1];
			neg_y[0] <= num_y[NW-1] ^ den[RW-1];
			sd[0]    <= side_in;
		end
	end

	// one quotient bit per stage
	for (genvar i = 0; i < QW; i++) begin : g_step
		logic [RW:0] tx, ty;
		logic        bx, by;

		always_comb begin
			tx = {rem_x[i], lo_x[i][QW-1]};
			ty = {rem_y[i], lo_y[i][QW-1]};
			bx = (tx >= {1'b0, dv[i]});
			by = (ty >= {1'b0, dv[i]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[i+1] <= 1'b0;
			end else if (en) begin
				vld[i+1] <= vld[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_x[i+1] <= bx ? RW'(tx - {1'b0, dv[i]}) : RW'(tx);
				rem_y[i+1] <= by ? RW'(ty - {1'b0, dv[i]}) : RW'(ty);
				lo_x[i+1]  <= {lo_x[i][QW-2:0], bx};
				lo_y[i+1]  <= {lo_y[i][QW-2:0], by};
				dv[i+1]    <= dv[i];
				neg_x[i+1] <= neg_x[i];
				neg_y[i+1] <= neg_y[i];
				sd[i+1]    <= sd[i];
			end
		end
	end

	// signed quotients, truncated toward zero
	always_comb begin
		res_vld  = vld[QW];
		side_res = sd[QW];
		quo_x    = neg_x[QW] ? -$signed({1'b0, lo_x[QW]}) : $signed({1'b0, lo_x[QW]});
		quo_y    = neg_y[QW] ? -$signed({1'b0, lo_y[QW]}) : $signed({1'b0, lo_y[QW]});
	end

`include "segment_intersection_core_assert.svh"

	// the quotient only fits, and so the remainder only settles, on a hit
	`SEGI_ASSERT(a_rem_below_div, (vld[QW] && sd[QW].status == segi_pkg::ST_HIT) |-> (rem_x[QW] < dv[QW] && rem_y[QW] < dv[QW]), "divider remainder not below divisor")
	`SEGI_ASSERT_ALWAYS(a_reset_empty, (!arst_n) |-> (vld[QW] !== 1'b1), "divider valid during reset")

endmodule
`default_nettype wire

// ===== src/segment_intersection_core.sv =====
// segment intersection core
// pipeline: input transfer to result through 4 arithmetic stages,
// a 17 stage one-bit-per-stage divider with its entry register, and an output register
// throughput: one segment pair per cycle; a stall at the output freezes the whole pipeline
// reset: arst_n clears all valid bits and sets the parallel threshold to 1
`default_nettype none
module segment_intersection_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [segi_pkg::THR_W-1:0]          cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [segi_pkg::COORD_W-1:0] ax,
	input  wire logic signed [segi_pkg::COORD_W-1:0] ay,
	input  wire logic signed [segi_pkg::COORD_W-1:0] bx,
	input  wire logic signed [segi_pkg::COORD_W-1:0] by_coord,
	input  wire logic signed [segi_pkg::COORD_W-1:0] cx,
	input  wire logic signed [segi_pkg::COORD_W-1:0] cy,
	input  wire logic signed [segi_pkg::COORD_W-1:0] dx,
	input  wire logic signed [segi_pkg::COORD_W-1:0] dy,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [1:0]                               status,
	output logic signed [segi_pkg::COORD_W-1:0]      px,
	output logic signed [segi_pkg::COORD_W-1:0]      py
);

	localparam int CW = segi_pkg::COORD_W;
	localparam int DW = segi_pkg::DIFF_W;
	localparam int PW = segi_pkg::PROD_W;
	localparam int XW = segi_pkg::CROSS_W;
	localparam int NW = segi_pkg::NUM_W;

	logic                  adv;
	logic [segi_pkg::THR_W-1:0] threshold_q;

	// threshold register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= segi_pkg::THR_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			threshold_q <= cfg_data;
		end
	end

	// whole pipeline moves unless a finished result is held up
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// stage 1: edge vectors
	logic                 vld_s1;
	logic signed [DW-1:0] abx_s1, aby_s1, cdx_s1, cdy_s1, acx_s1, acy_s1;
	logic signed [CW-1:0] ax_s1, ay_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			abx_s1 <= DW'(bx) - DW'(ax);
			aby_s1 <= DW'(by_coord) - DW'(ay);
			cdx_s1 <= DW'(dx) - DW'(cx);
			cdy_s1 <= DW'(dy) - DW'(cy);
			acx_s1 <= DW'(cx) - DW'(ax);
			acy_s1 <= DW'(cy) - DW'(ay);
			ax_s1  <= ax;
			ay_s1  <= ay;
		end
	end

	// stage 2: the six cross product terms
	logic                 vld_s2;
	logic signed [PW-1:0] p_abcd_s2, p_cdab_s2, p_t1_s2, p_t2_s2, p_u1_s2, p_u2_s2;
	logic signed [DW-1:0] abx_s2, aby_s2;
	logic signed [CW-1:0] ax_s2, ay_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_abcd_s2 <= abx_s1 * cdy_s1;
			p_cdab_s2 <= cdx_s1 * aby_s1;
			p_t1_s2   <= acx_s1 * cdy_s1;
			p_t2_s2   <= acy_s1 * cdx_s1;
			p_u1_s2   <= acx_s1 * aby_s1;
			p_u2_s2   <= acy_s1 * abx_s1;
			abx_s2    <= abx_s1;
			aby_s2    <= aby_s1;
			ax_s2     <= ax_s1;
			ay_s2     <= ay_s1;
		end
	end

	// stage 3: d and the t and u numerators
	logic                 vld_s3;
	logic signed [XW-1:0] d_s3, tn_s3, un_s3;
	logic signed [DW-1:0] abx_s3, aby_s3;
	logic signed [CW-1:0] ax_s3, ay_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s3   <= XW'(p_abcd_s2) - XW'(p_cdab_s2);
			tn_s3  <= XW'(p_t1_s2) - XW'(p_t2_s2);
			un_s3  <= XW'(p_u1_s2) - XW'(p_u2_s2);
			abx_s3 <= abx_s2;
			aby_s3 <= aby_s2;
			ax_s3  <= ax_s2;
			ay_s3  <= ay_s2;
		end
	end

	// stage 4: classification and the point numerators
	logic signed [XW:0] d_e, tn_e, un_e, dd, tnn, unn, mag_d;
	logic               par, t_ok, u_ok;
	logic [1:0]         st;

	always_comb begin
		d_e   = {d_s3[XW-1], d_s3};
		tn_e  = {tn_s3[XW-1], tn_s3};
		un_e  = {un_s3[XW-1], un_s3};
		dd    = d_s3[XW-1] ? -d_e : d_e;
		tnn   = d_s3[XW-1] ? -tn_e : tn_e;
		unn   = d_s3[XW-1] ? -un_e : un_e;
		mag_d = dd;
		par   = (d_s3 == '0) || ($unsigned(mag_d) < (XW+1)'(threshold_q));
		t_ok  = !tnn[XW] && (tnn <= dd);
		u_ok  = !unn[XW] && (unn <= dd);
		priority if (par) begin
			st = segi_pkg::ST_PARALLEL;
		end else if (!t_ok) begin
			st = segi_pkg::ST_T_OUT;
		end else if (!u_ok) begin
			st = segi_pkg::ST_U_OUT;
		end else begin
			st = segi_pkg::ST_HIT;
		end
	end

	logic                 vld_s4;
	logic signed [NW-1:0] nx_s4, ny_s4;
	logic signed [XW-1:0] d_s4;
	segi_pkg::side_t      side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s4          <= tn_s3 * abx_s3;
			ny_s4          <= tn_s3 * aby_s3;
			d_s4           <= d_s3;
			side_s4.status <= st;
			side_s4.ax     <= ax_s3;
			side_s4.ay     <= ay_s3;
		end
	end

	// offsets t*AB by long division
	logic                 div_vld;
	logic signed [DW:0]   qx, qy;
	segi_pkg::side_t      div_side;

	segi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s4),
		.num_x    (nx_s4),
		.num_y    (ny_s4),
		.den      (d_s4),
		.side_in  (side_s4),
		.res_vld  (div_vld),
		.quo_x    (qx),
		.quo_y    (qy),
		.side_res (div_side)
	);

	// output register: point only on a hit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status <= div_side.status;
			if (div_side.status == segi_pkg::ST_HIT) begin
				px <= div_side.ax + qx[CW-1:0];
				py <= div_side.ay + qy[CW-1:0];
			end else begin
				px <= '0;
				py <= '0;
			end
		end
	end

`include "segment_intersection_core_assert.svh"

	`SEGI_ASSERT(a_miss_zero, (out_valid && status != segi_pkg::ST_HIT) |-> (px == '0 && py == '0), "point not zero on a miss")
	`SEGI_ASSERT(a_stall_link, in_stall == (out_valid && out_stall), "input stall out of step with output")
	`SEGI_ASSERT(a_thr_hold, (!(cfg_valid && cfg_ready)) |=> $stable(threshold_q), "threshold changed without a transfer")
	`SEGI_ASSERT_ALWAYS(a_reset_idle, (!arst_n) |-> (out_valid !== 1'b1), "output valid during reset")

endmodule
`default_nettype wire

// ===== dv/segment_intersection_core_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
module segment_intersection_core_test;

	localparam int CW = segi_pkg::COORD_W;

	typedef struct {
		logic signed [segi_pkg::COORD_W-1:0] ax, ay, bx, by, cx, cy, dx, dy;
	} seg_pair_t;

	typedef struct {
		logic [1:0]                          status;
		logic signed [segi_pkg::COORD_W-1:0] px, py;
	} crossing_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [segi_pkg::THR_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [segi_pkg::COORD_W-1:0] ax = '0, ay = '0, bx = '0, by_coord = '0;
	logic signed [segi_pkg::COORD_W-1:0] cx = '0, cy = '0, dx = '0, dy = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic signed [segi_pkg::COORD_W-1:0] px, py;

	seg_pair_t pair_q[$];
	crossing_t crossing_q[$];
	logic [segi_pkg::THR_W-1:0] thr_model = 1;
	int errors = 0;
	int n_sent = 0, n_got = 0;
	int hist[4] = '{0, 0, 0, 0};
	bit quiet = 1'b0;
	int in_gap = 0, out_gap = 0;
	bit cfg_done = 1'b0;

	segment_intersection_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.ax(ax), .ay(ay), .bx(bx), .by_coord(by_coord),
		.cx(cx), .cy(cy), .dx(dx), .dy(dy),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .px(px), .py(py)
	);

	always #4 clk = ~clk;

	// expected crossing for one segment pair
	function automatic crossing_t predict_crossing(seg_pair_t s);
		crossing_t r;
		longint abx, aby, cdx, cdy, acx, acy, d, tn, un, md, nt, nu;
		abx = s.bx - s.ax; aby = s.by - s.ay;
		cdx = s.dx - s.cx; cdy = s.dy - s.cy;
		acx = s.cx - s.ax; acy = s.cy - s.ay;
		d = abx * cdy - cdx * aby;
		r.status = segi_pkg::ST_HIT; r.px = '0; r.py = '0;
		md = d < 0 ? -d : d;
		if (d == 0 || md < longint'({32'd0, thr_model})) begin
			r.status = segi_pkg::ST_PARALLEL;
		end else begin
			tn = acx * cdy - acy * cdx;
			un = acx * aby - acy * abx;
			nt = d < 0 ? -tn : tn;
			nu = d < 0 ? -un : un;
			if (!(nt >= 0 && nt <= md)) begin
				r.status = segi_pkg::ST_T_OUT;
			end else if (!(nu >= 0 && nu <= md)) begin
				r.status = segi_pkg::ST_U_OUT;
			end else begin
				r.px = CW'(s.ax + (tn * abx) / d);
				r.py = CW'(s.ay + (tn * aby) / d);
			end
		end
		return r;
	endfunction

	task automatic report(string what);
		errors++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	function automatic logic signed [segi_pkg::COORD_W-1:0] rnd_coord();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return CW'($urandom_range(0, 63) - 32);
			default: return CW'($urandom());
		endcase
	endfunction

	function automatic seg_pair_t mk(int a0, int a1, int b0, int b1,
			int c0, int c1, int d0, int d1);
		seg_pair_t s;
		s.ax = CW'(a0); s.ay = CW'(a1); s.bx = CW'(b0); s.by = CW'(b1);
		s.cx = CW'(c0); s.cy = CW'(c1); s.dx = CW'(d0); s.dy = CW'(d1);
		return s;
	endfunction

	// pair whose segments straddle the origin and so often cross, at a span of 400 or 16000
	function automatic seg_pair_t crossing_pair();
		seg_pair_t s;
		int span;
		span = $urandom_range(0, 3) == 0 ? 16000 : 400;
		s.ax = CW'(-$urandom_range(0, span));
		s.ay = CW'($urandom_range(0, span) - span / 2);
		s.bx = CW'($urandom_range(0, span));
		s.by = CW'($urandom_range(0, span) - span / 2);
		s.cx = CW'($urandom_range(0, span) - span / 2);
		s.cy = CW'(-$urandom_range(0, span));
		s.dx = CW'($urandom_range(0, span) - span / 2);
		s.dy = CW'($urandom_range(0, span));
		return s;
	endfunction

	// input driver: one transfer per accepted edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				crossing_q.push_back(predict_crossing(pair_q.pop_front()));
				n_sent++;
			end
			if (in_valid && in_stall) begin
			end else if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (pair_q.size() > 0 && cfg_done) begin
				seg_pair_t s;
				s = pair_q[0];
				if (!quiet && $urandom_range(0, 9) == 0) begin
					in_gap <= $urandom_range(0, 3);
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					ax <= s.ax; ay <= s.ay; bx <= s.bx; by_coord <= s.by;
					cx <= s.cx; cy <= s.cy; dx <= s.dx; dy <= s.dy;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output monitor with random stall bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				crossing_t e;
				n_got++;
				if (crossing_q.size() == 0) begin
					report("result with nothing expected");
				end else begin
					e = crossing_q.pop_front();
					hist[e.status]++;
					if (status !== e.status)
						report($sformatf("status %0d want %0d", status, e.status));
					if (px !== e.px) report($sformatf("px %0d want %0d", px, e.px));
					if (py !== e.py) report($sformatf("py %0d want %0d", py, e.py));
				end
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				out_gap <= $urandom_range(0, 3);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// register write while the pipeline is empty
	task automatic write_threshold(logic [segi_pkg::THR_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		thr_model = v;
	endtask

	task automatic drain();
		wait (pair_q.size() == 0 && !in_valid && crossing_q.size() == 0);
		repeat (30) @(posedge clk);
	endtask

	initial begin
		logic [segi_pkg::THR_W-1:0] thr_set[5];
		thr_set = '{32'd1, 32'd0, 32'd5000, 32'hffff_ffff, 32'd1};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		cfg_done = 1'b1;

		// directed pairs at reset threshold
		pair_q.push_back(mk(0, 0, 160, 160, 0, 160, 160, 0));
		pair_q.push_back(mk(0, 0, 16, 0, 0, 16, 16, 16));
		pair_q.push_back(mk(0, 0, 0, 0, 5, 5, 9, 1));
		pair_q.push_back(mk(0, 0, 16, 0, 16, -16, 16, 16));
		pair_q.push_back(mk(0, 0, 16, 0, 0, -16, 0, 16));
		pair_q.push_back(mk(0, 0, 16, 0, 32, -16, 32, 16));
		pair_q.push_back(mk(0, 0, 16, 0, 8, 4, 8, 16));
		pair_q.push_back(mk(0, 0, 16, 0, 40, 4, 40, 16));
		pair_q.push_back(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
		pair_q.push_back(mk(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768));
		pair_q.push_back(mk(-32768, 0, 32767, 0, 0, -32768, 1, 32767));
		pair_q.push_back(mk(0, 0, 3, 7, 0, 0, 7, 3));
		pair_q.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1));
		drain();

		// random phases across threshold settings
		foreach (thr_set[k]) begin
			write_threshold(thr_set[k]);
			cfg_done = 1'b1;
			if (k == 4) quiet = 1'b1;
			for (int i = 0; i < 140; i++) begin
				if ($urandom_range(0, 9) < 7) pair_q.push_back(crossing_pair());
				else pair_q.push_back(mk(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
					rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()));
			end
			cfg_done = 1'b1;
			drain();
		end

		$display("sent %0d pairs, got %0d results over five threshold settings", n_sent, n_got);
		$display("hit %0d, parallel %0d, t out %0d, u out %0d",
			hist[0], hist[1], hist[2], hist[3]);
		if (errors == 0 && crossing_q.size() == 0)
			$display("segment_intersection_core_test: done, clean");
		else
			$display("segment_intersection_core_test: done, errors");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("segment_intersection_core_test: done, errors");
		$finish;
	end
endmodule
`default_nettype wire
